// File: rtl/core/sitoa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared constants and types for the signed integer to decimal text block.
// ----------------------------------------------------------------------------
package sitoa_pkg;

    localparam int VALUE_BITS_DEF = 32;

    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] MINUS_SIGN = 8'h2D;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_CONV  = 5'b00010,
        ST_LEAD  = 5'b00100,
        ST_SIGN  = 5'b01000,
        ST_DIGIT = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic lead;
        logic next;
        logic show_sign;
    } t_cmd;

    typedef struct packed {
        logic neg;
        logic idx_zero;
    } t_status;

endpackage : sitoa_pkg
`default_nettype wire

// File: rtl/core/sitoa_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_datapath
// Magnitude capture, shift-and-add-3 conversion four bits per cycle, leading
// digit search and character formation.
// ----------------------------------------------------------------------------
module sitoa_datapath #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
    input  wire                           i_clk,
    input  wire sitoa_pkg::t_cmd          i_cmd,
    input  wire signed [VALUE_BITS-1:0]   i_value,
    output sitoa_pkg::t_status            o_status,
    output logic [7:0]                    o_character,
    output logic                          o_last
);

    localparam int MAG_W = ((VALUE_BITS + 3) / 4) * 4;
    localparam int ND    = ((VALUE_BITS - 1) * 1233) / 4096 + 1;
    localparam int BCD_W = ND * 4;
    localparam int IDX_W = $clog2(ND);

    logic [MAG_W-1:0]      r_mag;
    logic [MAG_W-1:0]      n_mag;
    logic [BCD_W-1:0]      r_bcd;
    logic [BCD_W-1:0]      n_bcd;
    logic                  r_neg;
    logic [IDX_W-1:0]      r_idx;
    logic [IDX_W-1:0]      lead_idx;
    logic [VALUE_BITS-1:0] raw;
    logic [VALUE_BITS-1:0] abs_val;
    logic [3:0]            digit;

    assign raw     = i_value;
    assign abs_val = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;

    always_comb begin
        n_bcd = r_bcd;
        n_mag = r_mag;
        for (int s = 0; s < 4; s++) begin
            for (int d = 0; d < ND; d++) begin
                if (n_bcd[d*4 +: 4] >= 4'd5) begin
                    n_bcd[d*4 +: 4] = n_bcd[d*4 +: 4] + 4'd3;
                end
            end
            n_bcd = {n_bcd[BCD_W-2:0], n_mag[MAG_W-1]};
            n_mag = {n_mag[MAG_W-2:0], 1'b0};
        end
    end

    always_comb begin
        lead_idx = '0;
        for (int d = 0; d < ND; d++) begin
            if (r_bcd[d*4 +: 4] != 4'd0) begin
                lead_idx = IDX_W'(d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= MAG_W'(abs_val);
            r_bcd <= '0;
            r_neg <= raw[VALUE_BITS-1];
        end else if (i_cmd.conv) begin
            r_mag <= n_mag;
            r_bcd <= n_bcd;
        end
        if (i_cmd.lead) begin
            r_idx <= lead_idx;
        end else if (i_cmd.next) begin
            r_idx <= r_idx - 1'b1;
        end
    end

    assign digit             = r_bcd[{r_idx, 2'b00} +: 4];
    assign o_status.neg      = r_neg;
    assign o_status.idx_zero = (r_idx == '0);
    assign o_character       = i_cmd.show_sign ? sitoa_pkg::MINUS_SIGN
                                               : (sitoa_pkg::DIGIT_ZERO + {4'd0, digit});
    assign o_last            = !i_cmd.show_sign && (r_idx == '0);

endmodule : sitoa_datapath
`default_nettype wire

// File: rtl/core/sitoa_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sitoa_ctrl
// Sequencer for capture, conversion steps, leading digit load and the
// character output handshake.
// ----------------------------------------------------------------------------
module sitoa_ctrl #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_in_valid,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    input  wire                   i_out_stall,
    input  wire sitoa_pkg::t_status i_status,
    output sitoa_pkg::t_cmd       o_cmd
);

    localparam int STEPS  = (VALUE_BITS + 3) / 4;
    localparam int STEP_W = $clog2(STEPS);

    sitoa_pkg::t_state r_state;
    sitoa_pkg::t_state n_state;
    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            sitoa_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_step     = '0;
                    n_state    = sitoa_pkg::ST_CONV;
                end
            end
            sitoa_pkg::ST_CONV: begin
                o_cmd.conv = 1'b1;
                n_step     = r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    n_state = sitoa_pkg::ST_LEAD;
                end
            end
            sitoa_pkg::ST_LEAD: begin
                o_cmd.lead = 1'b1;
                n_state    = i_status.neg ? sitoa_pkg::ST_SIGN : sitoa_pkg::ST_DIGIT;
            end
            sitoa_pkg::ST_SIGN: begin
                o_cmd.show_sign = 1'b1;
                if (!i_out_stall) begin
                    n_state = sitoa_pkg::ST_DIGIT;
                end
            end
            sitoa_pkg::ST_DIGIT: begin
                if (!i_out_stall) begin
                    if (i_status.idx_zero) begin
                        n_state = sitoa_pkg::ST_IDLE;
                    end else begin
                        o_cmd.next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = sitoa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sitoa_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    assign o_in_stall  = !i_rst_n || (r_state != sitoa_pkg::ST_IDLE);
    assign o_out_valid = (r_state == sitoa_pkg::ST_SIGN) || (r_state == sitoa_pkg::ST_DIGIT);

`ifndef SYNTH
    a_accept_starts_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state == sitoa_pkg::ST_CONV))
        else $error("Accepted item did not start conversion.");

    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sitoa_pkg::ST_DIGIT && !i_out_stall && i_status.idx_zero)
        |=> (r_state == sitoa_pkg::ST_IDLE))
        else $error("Final character did not return the sequencer to idle.");

    a_sign_only_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sitoa_pkg::ST_SIGN) |-> i_status.neg)
        else $error("Minus sign emitted for a non-negative value.");

    a_conv_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sitoa_pkg::ST_LEAD) |-> $past(r_step) == STEP_W'(STEPS - 1))
        else $error("Conversion ended after the wrong number of steps.");
`endif

endmodule : sitoa_ctrl
`default_nettype wire

// File: rtl/core/signed_int_to_decimal_ascii.sv
`default_nettype none
// The first character is valid after the capture (ST_IDLE), the conversion steps (ST_CONV) and ST_LEAD.
// An item gives N characters (1 to 11); no new item is accepted until its last character has left.
// Conversion is done by the shift-and-add-3 unit, four magnitude bits per cycle.
// Characters then leave one per cycle while the output is not stalled.
// Reset is synchronous, active low, returns the sequencer to idle and stalls the input.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts a signed two's complement integer into its decimal ASCII text,
// most significant character first, with the final character flagged.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
    parameter int VALUE_BITS = sitoa_pkg::VALUE_BITS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire signed [VALUE_BITS-1:0] i_value,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [7:0]                  o_character,
    output logic                        o_last
);

    sitoa_pkg::t_cmd    cmd;
    sitoa_pkg::t_status status;

    sitoa_ctrl #(
        .VALUE_BITS (VALUE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    sitoa_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .o_status    (status),
        .o_character (o_character),
        .o_last      (o_last)
    );

endmodule : signed_int_to_decimal_ascii
`default_nettype wire
